/* sv/gaussian_density_eval_core_assert.svh */
// ----------------------------------------------------------------------------
// gaussian density evaluator assertion macros
// shared property forms for the concurrent checks of the core
// ----------------------------------------------------------------------------
`ifndef GAUSSIAN_DENSITY_EVAL_CORE_ASSERT_SVH
`define GAUSSIAN_DENSITY_EVAL_CORE_ASSERT_SVH

// same-cycle implication, held off during reset
`define GDE_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("gde same-cycle check failed");

// next-cycle implication, held off during reset
`define GDE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("gde next-cycle check failed");

`endif

/* sv/gde_pkg.sv */
// ----------------------------------------------------------------------------
// gde_pkg
// widths, constants, pipeline control type and the 2^-f table
// ----------------------------------------------------------------------------
package gde_pkg;

  localparam int FRAC_BITS           = 16;
  localparam int EXP_TABLE_ADDR_BITS = 8;
  localparam int IQ                  = 30;
  localparam int UQ                  = 24;
  localparam int SERIES_TERMS        = 24;

  localparam int X_W      = 24;
  localparam int MEAN_W   = 21;
  localparam int SIG_W    = 20;
  localparam int DENS_W   = 32;
  localparam int D_W      = X_W + 1;
  localparam int AD_W     = X_W;
  localparam int Q_W      = 2 * AD_W;
  localparam int DEN_W    = 2 * SIG_W + 1;
  localparam int QLO_W    = 6;                 // integer bits of the exponent argument
  localparam int P1_W     = Q_W - QLO_W;
  localparam int U_W      = QLO_W + UQ;
  localparam int V_W      = 31;
  localparam int N_W      = V_W - UQ;
  localparam int IDX_W    = EXP_TABLE_ADDR_BITS;
  localparam int LO_W     = UQ - EXP_TABLE_ADDR_BITS;
  localparam int ROM_LEN  = (1 << EXP_TABLE_ADDR_BITS) + 1;
  localparam int ROM_AW   = EXP_TABLE_ADDR_BITS + 1;
  localparam int ROM_W    = 32;
  localparam int NUM_W    = 31;
  localparam int RND_SH   = 2 * FRAC_BITS - IQ + 1;
  localparam int DVD_W    = 36;
  localparam int MAX_N    = 34 + 2 * FRAC_BITS - IQ;

  localparam int U_STG    = 15;
  localparam int U_STEPS  = 2;
  localparam int R_STG    = 9;
  localparam int R_STEPS  = 4;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = MEAN_W;
  localparam logic [CFG_IDX_W-1:0] REG_MEAN  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_SIGMA = 1'b1;

  localparam logic [MEAN_W-1:0] MEAN_RST  = '0;
  localparam logic [SIG_W-1:0]  SIGMA_RST = 20'd65536;

  localparam logic [63:0] LN2_Q30          = 64'd744261118;
  localparam logic [30:0] LOG2E_Q30        = 31'd1549082005;
  localparam logic [28:0] INV_SQRT_2PI_Q30 = 29'd428361012;

  typedef struct packed {
    logic vld;
    logic tail;
  } ctl_t;

  typedef logic [ROM_W-1:0] rom_t [ROM_LEN];

  // 2^-(k/2^A) in q30 from a truncated series of exp(-t)
  function automatic rom_t build_rom();
    rom_t               rom;
    logic [63:0]        t;
    logic [63:0]        term;
    logic signed [63:0] acc;
    for (int k = 0; k < ROM_LEN; k++) begin
      t    = (64'(k) * LN2_Q30) >> EXP_TABLE_ADDR_BITS;
      acc  = 64'sd1 <<< IQ;
      term = 64'd1 << IQ;
      for (int j = 1; j <= SERIES_TERMS; j++) begin
        term = ((term * t) >> IQ) / 64'(j);
        if ((j % 2) == 1) begin
          acc = acc - $signed(term);
        end else begin
          acc = acc + $signed(term);
        end
      end
      rom[k] = acc[ROM_W-1:0];
    end
    return rom;
  endfunction

  localparam rom_t POW2_ROM = build_rom();

endpackage

/* sv/gaussian_density_eval_core.sv */
// ----------------------------------------------------------------------------
// gaussian_density_eval_core
// normal density of one sample per word, mean and sigma set by registers
//
// in_sample_x (signed q8.16) enters on in_valid/in_ready; out_density
// (unsigned q16.16) and out_saturated leave on out_valid/out_ready.
// mean (index 0) and sigma (index 1) must be written through cfg_we while idle;
// the core itself does not enforce it. out_valid rises once the word passes 3
// front stages (the first loaded at the accepting edge), 15 stages of the
// exponent divider (2 bits each), 5 exponential stages, 9 stages of the final
// divider (4 bits each) and the output register.
// throughput is one word per cycle, set by the fully pipelined dividers, but
// when the receiver stalls, the pipeline advances until a word leaves it into
// a skid register, then freezes; in_ready drops only while the skid is full.
// synchronous reset empties the pipeline and sets mean 0, sigma 1.0.
// ----------------------------------------------------------------------------
`include "gaussian_density_eval_core_assert.svh"

module gaussian_density_eval_core (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [gde_pkg::X_W-1:0]        in_sample_x,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [gde_pkg::DENS_W-1:0]            out_density,
  output logic                                  out_saturated,
  input  logic                                  cfg_we,
  input  logic [gde_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [gde_pkg::CFG_DATA_W-1:0]        cfg_data
);

  logic signed [gde_pkg::MEAN_W-1:0] mean_r;
  logic [gde_pkg::SIG_W-1:0]         sigma_r;
  logic                              en;

  gde_pkg::ctl_t                fr_ctl, ud_ctl, ex_ctl, rd_ctl;
  logic [gde_pkg::P1_W-1:0]     fr_p;
  logic [gde_pkg::QLO_W-1:0]    fr_qlo;
  logic [gde_pkg::DEN_W-1:0]    fr_den;
  logic [gde_pkg::SIG_W-1:0]    fr_sg, ud_sg, ex_sg;
  logic [gde_pkg::U_W-1:0]      ud_u;
  logic [gde_pkg::DVD_W-1:0]    ex_dvd, rd_quo;
  logic [gde_pkg::N_W-1:0]      ex_n, rd_n;

  logic [gde_pkg::DVD_W-1:0]    shq;
  logic [gde_pkg::DVD_W:0]      rnd;
  logic [gde_pkg::DENS_W-1:0]   res_d;
  logic                         res_s;

  logic                         out_v_r, out_v_nxt;
  logic [gde_pkg::DENS_W-1:0]   out_d_r, out_d_nxt;
  logic                         out_s_r, out_s_nxt;
  logic                         sk_v_r, sk_v_nxt;
  logic [gde_pkg::DENS_W-1:0]   sk_d_r, sk_d_nxt;
  logic                         sk_s_r, sk_s_nxt;
  logic                         out_take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mean_r  <= gde_pkg::MEAN_RST;
      sigma_r <= gde_pkg::SIGMA_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        gde_pkg::REG_MEAN:  mean_r  <= $signed(cfg_data);
        gde_pkg::REG_SIGMA: sigma_r <= cfg_data[gde_pkg::SIG_W-1:0];
        default: ;
      endcase
    end
  end

  // the whole pipeline moves unless a word sits in the skid register
  assign en       = !sk_v_r;
  assign in_ready = en;

  gde_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (in_valid),
    .x_i     (in_sample_x),
    .mean_i  (mean_r),
    .sigma_i (sigma_r),
    .ctl_o   (fr_ctl),
    .p_o     (fr_p),
    .qlo_o   (fr_qlo),
    .den_o   (fr_den),
    .sg_o    (fr_sg)
  );

  gde_udiv u_udiv (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .ctl_i (fr_ctl),
    .p_i   (fr_p),
    .qlo_i (fr_qlo),
    .den_i (fr_den),
    .sg_i  (fr_sg),
    .ctl_o (ud_ctl),
    .u_o   (ud_u),
    .sg_o  (ud_sg)
  );

  gde_exp2 u_exp2 (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .ctl_i (ud_ctl),
    .u_i   (ud_u),
    .sg_i  (ud_sg),
    .ctl_o (ex_ctl),
    .dvd_o (ex_dvd),
    .n_o   (ex_n),
    .sg_o  (ex_sg)
  );

  gde_rdiv u_rdiv (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .ctl_i (ex_ctl),
    .dvd_i (ex_dvd),
    .n_i   (ex_n),
    .sg_i  (ex_sg),
    .ctl_o (rd_ctl),
    .quo_o (rd_quo),
    .n_o   (rd_n)
  );

  // integer exponent as a right shift, then round half up on the last bit
  always_comb begin
    shq   = rd_quo >> rd_n;
    rnd   = (gde_pkg::DVD_W+1)'(shq) + (gde_pkg::DVD_W+1)'(1);
    res_d = '0;
    res_s = 1'b0;
    if (rd_ctl.tail || (rd_n > gde_pkg::N_W'(gde_pkg::MAX_N))) begin
      res_d = '0;
    end else if (rnd[gde_pkg::DVD_W:gde_pkg::DENS_W+1] != '0) begin
      res_d = '1;
      res_s = 1'b1;
    end else begin
      res_d = rnd[gde_pkg::DENS_W:1];
    end
  end

  always_comb begin
    out_take  = !out_v_r || out_ready;
    out_v_nxt = out_v_r;
    out_d_nxt = out_d_r;
    out_s_nxt = out_s_r;
    sk_v_nxt  = sk_v_r;
    sk_d_nxt  = sk_d_r;
    sk_s_nxt  = sk_s_r;
    if (sk_v_r) begin
      if (out_take) begin
        out_v_nxt = 1'b1;
        out_d_nxt = sk_d_r;
        out_s_nxt = sk_s_r;
        sk_v_nxt  = 1'b0;
      end
    end else if (out_take) begin
      out_v_nxt = rd_ctl.vld;
      out_d_nxt = res_d;
      out_s_nxt = res_s;
    end else if (rd_ctl.vld) begin
      sk_v_nxt = 1'b1;
      sk_d_nxt = res_d;
      sk_s_nxt = res_s;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
      sk_v_r  <= 1'b0;
    end else begin
      out_v_r <= out_v_nxt;
      sk_v_r  <= sk_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_d_r <= out_d_nxt;
    out_s_r <= out_s_nxt;
    sk_d_r  <= sk_d_nxt;
    sk_s_r  <= sk_s_nxt;
  end

  assign out_valid     = out_v_r;
  assign out_density   = out_d_r;
  assign out_saturated = out_s_r;

  `GDE_ASSERT_IMPLY(a_skid_behind_out, sk_v_r, out_v_r)
  `GDE_ASSERT_NEXT(a_skid_holds, sk_v_r && !out_ready, sk_v_r && $stable(sk_d_r))
  `GDE_ASSERT_IMPLY(a_sat_all_ones, out_v_r && out_s_r, out_d_r == '1)

endmodule

/* sv/gde_front.sv */
// ----------------------------------------------------------------------------
// gde_front
// offset from the mean, its square, twice sigma squared and the tail check
// ----------------------------------------------------------------------------
module gde_front (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                en,
  input  logic                                in_vld,
  input  logic signed [gde_pkg::X_W-1:0]      x_i,
  input  logic signed [gde_pkg::MEAN_W-1:0]   mean_i,
  input  logic [gde_pkg::SIG_W-1:0]           sigma_i,
  output gde_pkg::ctl_t                       ctl_o,
  output logic [gde_pkg::P1_W-1:0]            p_o,
  output logic [gde_pkg::QLO_W-1:0]           qlo_o,
  output logic [gde_pkg::DEN_W-1:0]           den_o,
  output logic [gde_pkg::SIG_W-1:0]           sg_o
);

  logic signed [gde_pkg::D_W-1:0] diff;
  logic [gde_pkg::D_W-1:0]        mag;
  logic [2*gde_pkg::SIG_W-1:0]    sq;

  logic                           v1_r;
  logic                           v2_r;
  logic [gde_pkg::AD_W-1:0]       ad1_r, ad1_nxt;
  logic [gde_pkg::SIG_W-1:0]      sg1_r, sg1_nxt;
  logic [gde_pkg::SIG_W-1:0]      sg2_r;
  logic [gde_pkg::Q_W-1:0]        q2_r, q2_nxt;
  logic [gde_pkg::DEN_W-1:0]      den2_r, den2_nxt;
  gde_pkg::ctl_t                  ctl3_r, ctl3_nxt;
  logic [gde_pkg::P1_W-1:0]       p3_r;
  logic [gde_pkg::QLO_W-1:0]      qlo3_r;
  logic [gde_pkg::DEN_W-1:0]      den3_r;
  logic [gde_pkg::SIG_W-1:0]      sg3_r;

  always_comb begin
    diff    = gde_pkg::D_W'(x_i) - gde_pkg::D_W'(mean_i);
    mag     = diff[gde_pkg::D_W-1] ? gde_pkg::D_W'(-diff) : gde_pkg::D_W'(diff);
    ad1_nxt = mag[gde_pkg::AD_W-1:0];
    // a zero sigma counts as one lsb
    sg1_nxt = (sigma_i == '0) ? gde_pkg::SIG_W'(1) : sigma_i;
    q2_nxt  = gde_pkg::Q_W'(ad1_r) * gde_pkg::Q_W'(ad1_r);
    sq      = (2*gde_pkg::SIG_W)'(sg1_r) * (2*gde_pkg::SIG_W)'(sg1_r);
    den2_nxt = {sq, 1'b0};
    ctl3_nxt.vld  = v2_r;
    // argument of the exponential at or beyond the cutoff
    ctl3_nxt.tail = q2_r >= {1'b0, den2_r, {gde_pkg::QLO_W{1'b0}}};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r   <= 1'b0;
      v2_r   <= 1'b0;
      ctl3_r <= '0;
    end else if (en) begin
      v1_r   <= in_vld;
      v2_r   <= v1_r;
      ctl3_r <= ctl3_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ad1_r  <= ad1_nxt;
      sg1_r  <= sg1_nxt;
      q2_r   <= q2_nxt;
      den2_r <= den2_nxt;
      sg2_r  <= sg1_r;
      p3_r   <= q2_r[gde_pkg::Q_W-1:gde_pkg::QLO_W];
      qlo3_r <= q2_r[gde_pkg::QLO_W-1:0];
      den3_r <= den2_r;
      sg3_r  <= sg2_r;
    end
  end

  assign ctl_o = ctl3_r;
  assign p_o   = p3_r;
  assign qlo_o = qlo3_r;
  assign den_o = den3_r;
  assign sg_o  = sg3_r;

endmodule

/* sv/gde_udiv.sv */
// ----------------------------------------------------------------------------
// gde_udiv
// pipelined restoring divider: squared offset over twice sigma squared
// ----------------------------------------------------------------------------
module gde_udiv (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            en,
  input  gde_pkg::ctl_t                   ctl_i,
  input  logic [gde_pkg::P1_W-1:0]        p_i,
  input  logic [gde_pkg::QLO_W-1:0]       qlo_i,
  input  logic [gde_pkg::DEN_W-1:0]       den_i,
  input  logic [gde_pkg::SIG_W-1:0]       sg_i,
  output gde_pkg::ctl_t                   ctl_o,
  output logic [gde_pkg::U_W-1:0]         u_o,
  output logic [gde_pkg::SIG_W-1:0]       sg_o
);

  gde_pkg::ctl_t                ctl_r  [gde_pkg::U_STG];
  logic [gde_pkg::P1_W-1:0]     p_r    [gde_pkg::U_STG];
  logic [gde_pkg::QLO_W-1:0]    bits_r [gde_pkg::U_STG];
  logic [gde_pkg::U_W-1:0]      quo_r  [gde_pkg::U_STG];
  logic [gde_pkg::DEN_W-1:0]    den_r  [gde_pkg::U_STG];
  logic [gde_pkg::SIG_W-1:0]    sg_r   [gde_pkg::U_STG];

  // one quotient bit: msb is the bit, rest the new partial remainder
  function automatic logic [gde_pkg::P1_W:0] div_step(
    input logic [gde_pkg::P1_W-1:0]  p,
    input logic                      b,
    input logic [gde_pkg::DEN_W-1:0] dv
  );
    logic [gde_pkg::P1_W:0] pp;
    logic [gde_pkg::P1_W:0] dx;
    pp = {p, b};
    dx = (gde_pkg::P1_W+1)'(dv);
    if (pp >= dx) begin
      return {1'b1, gde_pkg::P1_W'(pp - dx)};
    end
    return {1'b0, pp[gde_pkg::P1_W-1:0]};
  endfunction

  for (genvar i = 0; i < gde_pkg::U_STG; i++) begin : g_stg
    gde_pkg::ctl_t             ctl_in;
    logic [gde_pkg::P1_W-1:0]  p_in;
    logic [gde_pkg::QLO_W-1:0] bits_in;
    logic [gde_pkg::U_W-1:0]   quo_in;
    logic [gde_pkg::DEN_W-1:0] den_in;
    logic [gde_pkg::SIG_W-1:0] sg_in;
    logic [gde_pkg::P1_W:0]    st;
    logic [gde_pkg::P1_W-1:0]  p_nxt;
    logic [gde_pkg::QLO_W-1:0] bits_nxt;
    logic [gde_pkg::U_W-1:0]   quo_nxt;

    if (i == 0) begin : g_head
      assign ctl_in  = ctl_i;
      assign p_in    = p_i;
      assign bits_in = qlo_i;
      assign quo_in  = '0;
      assign den_in  = den_i;
      assign sg_in   = sg_i;
    end else begin : g_body
      assign ctl_in  = ctl_r[i-1];
      assign p_in    = p_r[i-1];
      assign bits_in = bits_r[i-1];
      assign quo_in  = quo_r[i-1];
      assign den_in  = den_r[i-1];
      assign sg_in   = sg_r[i-1];
    end

    always_comb begin
      p_nxt    = p_in;
      bits_nxt = bits_in;
      quo_nxt  = quo_in;
      st       = '0;
      for (int k = 0; k < gde_pkg::U_STEPS; k++) begin
        st       = div_step(p_nxt, bits_nxt[gde_pkg::QLO_W-1], den_in);
        p_nxt    = st[gde_pkg::P1_W-1:0];
        quo_nxt  = {quo_nxt[gde_pkg::U_W-2:0], st[gde_pkg::P1_W]};
        bits_nxt = {bits_nxt[gde_pkg::QLO_W-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        ctl_r[i] <= '0;
      end else if (en) begin
        ctl_r[i] <= ctl_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        p_r[i]    <= p_nxt;
        bits_r[i] <= bits_nxt;
        quo_r[i]  <= quo_nxt;
        den_r[i]  <= den_in;
        sg_r[i]   <= sg_in;
      end
    end
  end

  assign ctl_o = ctl_r[gde_pkg::U_STG-1];
  assign u_o   = quo_r[gde_pkg::U_STG-1];
  assign sg_o  = sg_r[gde_pkg::U_STG-1];

endmodule

/* sv/gde_exp2.sv */
// ----------------------------------------------------------------------------
// gde_exp2
// base-2 exponent, table lookup with interpolation, scale by 1/sqrt(2 pi)
// ----------------------------------------------------------------------------
module gde_exp2 (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            en,
  input  gde_pkg::ctl_t                   ctl_i,
  input  logic [gde_pkg::U_W-1:0]         u_i,
  input  logic [gde_pkg::SIG_W-1:0]       sg_i,
  output gde_pkg::ctl_t                   ctl_o,
  output logic [gde_pkg::DVD_W-1:0]       dvd_o,
  output logic [gde_pkg::N_W-1:0]         n_o,
  output logic [gde_pkg::SIG_W-1:0]       sg_o
);

  localparam int P1L = gde_pkg::U_W + gde_pkg::V_W;
  localparam int P3L = gde_pkg::ROM_W + gde_pkg::LO_W;
  localparam int P5L = 64;

  logic [P1L-1:0]               prod1;
  logic [gde_pkg::ROM_W-1:0]    rom_a, rom_b;
  logic [gde_pkg::IDX_W-1:0]    idx;
  logic [P3L-1:0]               prod3;
  logic [P5L-1:0]               prod5;

  gde_pkg::ctl_t                ctl1_r, ctl2_r, ctl3_r, ctl4_r, ctl5_r;
  logic [gde_pkg::V_W-1:0]      v1_r, v1_nxt;
  logic [gde_pkg::SIG_W-1:0]    sg1_r, sg2_r, sg3_r, sg4_r, sg5_r;
  logic [gde_pkg::ROM_W-1:0]    a2_r, a3_r;
  logic [gde_pkg::ROM_W-1:0]    dif2_r, dif2_nxt;
  logic                         up2_r, up3_r, up2_nxt;
  logic [gde_pkg::LO_W-1:0]     lo2_r;
  logic [gde_pkg::N_W-1:0]      n2_r, n3_r, n4_r, n5_r;
  logic [gde_pkg::ROM_W-1:0]    ip3_r, ip3_nxt;
  logic [gde_pkg::ROM_W-1:0]    m4_r, m4_nxt;
  logic [gde_pkg::DVD_W-1:0]    dvd5_r, dvd5_nxt;

  always_comb begin
    // u times log2(e), 24 fraction bits kept
    prod1  = P1L'(u_i) * P1L'(gde_pkg::LOG2E_Q30);
    v1_nxt = prod1[P1L-1:gde_pkg::IQ];

    idx   = v1_r[gde_pkg::UQ-1:gde_pkg::LO_W];
    rom_a = gde_pkg::POW2_ROM[gde_pkg::ROM_AW'(idx)];
    rom_b = gde_pkg::POW2_ROM[gde_pkg::ROM_AW'(idx) + gde_pkg::ROM_AW'(1)];
    up2_nxt  = rom_b > rom_a;
    dif2_nxt = up2_nxt ? (rom_b - rom_a) : (rom_a - rom_b);

    prod3   = P3L'(dif2_r) * P3L'(lo2_r);
    ip3_nxt = prod3[P3L-1:gde_pkg::LO_W];

    m4_nxt = up3_r ? (a3_r + ip3_r) : (a3_r - ip3_r);

    prod5    = P5L'(gde_pkg::INV_SQRT_2PI_Q30) * P5L'(m4_r);
    // numerator with the rounding and output-format bits below it
    dvd5_nxt = gde_pkg::DVD_W'({prod5[gde_pkg::IQ+gde_pkg::NUM_W-1:gde_pkg::IQ],
                                {gde_pkg::RND_SH{1'b0}}});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl1_r <= '0;
      ctl2_r <= '0;
      ctl3_r <= '0;
      ctl4_r <= '0;
      ctl5_r <= '0;
    end else if (en) begin
      ctl1_r <= ctl_i;
      ctl2_r <= ctl1_r;
      ctl3_r <= ctl2_r;
      ctl4_r <= ctl3_r;
      ctl5_r <= ctl4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      v1_r   <= v1_nxt;
      sg1_r  <= sg_i;
      a2_r   <= rom_a;
      dif2_r <= dif2_nxt;
      up2_r  <= up2_nxt;
      lo2_r  <= v1_r[gde_pkg::LO_W-1:0];
      n2_r   <= v1_r[gde_pkg::V_W-1:gde_pkg::UQ];
      sg2_r  <= sg1_r;
      a3_r   <= a2_r;
      up3_r  <= up2_r;
      ip3_r  <= ip3_nxt;
      n3_r   <= n2_r;
      sg3_r  <= sg2_r;
      m4_r   <= m4_nxt;
      n4_r   <= n3_r;
      sg4_r  <= sg3_r;
      dvd5_r <= dvd5_nxt;
      n5_r   <= n4_r;
      sg5_r  <= sg4_r;
    end
  end

  assign ctl_o = ctl5_r;
  assign dvd_o = dvd5_r;
  assign n_o   = n5_r;
  assign sg_o  = sg5_r;

endmodule

/* sv/gde_rdiv.sv */
// ----------------------------------------------------------------------------
// gde_rdiv
// pipelined restoring divider: scaled numerator over sigma
// ----------------------------------------------------------------------------
module gde_rdiv (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            en,
  input  gde_pkg::ctl_t                   ctl_i,
  input  logic [gde_pkg::DVD_W-1:0]       dvd_i,
  input  logic [gde_pkg::N_W-1:0]         n_i,
  input  logic [gde_pkg::SIG_W-1:0]       sg_i,
  output gde_pkg::ctl_t                   ctl_o,
  output logic [gde_pkg::DVD_W-1:0]       quo_o,
  output logic [gde_pkg::N_W-1:0]         n_o
);

  gde_pkg::ctl_t                ctl_r  [gde_pkg::R_STG];
  logic [gde_pkg::SIG_W-1:0]    p_r    [gde_pkg::R_STG];
  logic [gde_pkg::DVD_W-1:0]    bits_r [gde_pkg::R_STG];
  logic [gde_pkg::DVD_W-1:0]    quo_r  [gde_pkg::R_STG];
  logic [gde_pkg::SIG_W-1:0]    sg_r   [gde_pkg::R_STG];
  logic [gde_pkg::N_W-1:0]      n_r    [gde_pkg::R_STG];

  function automatic logic [gde_pkg::SIG_W:0] div_step(
    input logic [gde_pkg::SIG_W-1:0] p,
    input logic                      b,
    input logic [gde_pkg::SIG_W-1:0] dv
  );
    logic [gde_pkg::SIG_W:0] pp;
    logic [gde_pkg::SIG_W:0] dx;
    pp = {p, b};
    dx = (gde_pkg::SIG_W+1)'(dv);
    if (pp >= dx) begin
      return {1'b1, gde_pkg::SIG_W'(pp - dx)};
    end
    return {1'b0, pp[gde_pkg::SIG_W-1:0]};
  endfunction

  for (genvar i = 0; i < gde_pkg::R_STG; i++) begin : g_stg
    gde_pkg::ctl_t             ctl_in;
    logic [gde_pkg::SIG_W-1:0] p_in;
    logic [gde_pkg::DVD_W-1:0] bits_in;
    logic [gde_pkg::DVD_W-1:0] quo_in;
    logic [gde_pkg::SIG_W-1:0] sg_in;
    logic [gde_pkg::N_W-1:0]   n_in;
    logic [gde_pkg::SIG_W:0]   st;
    logic [gde_pkg::SIG_W-1:0] p_nxt;
    logic [gde_pkg::DVD_W-1:0] bits_nxt;
    logic [gde_pkg::DVD_W-1:0] quo_nxt;

    if (i == 0) begin : g_head
      assign ctl_in  = ctl_i;
      assign p_in    = '0;
      assign bits_in = dvd_i;
      assign quo_in  = '0;
      assign sg_in   = sg_i;
      assign n_in    = n_i;
    end else begin : g_body
      assign ctl_in  = ctl_r[i-1];
      assign p_in    = p_r[i-1];
      assign bits_in = bits_r[i-1];
      assign quo_in  = quo_r[i-1];
      assign sg_in   = sg_r[i-1];
      assign n_in    = n_r[i-1];
    end

    always_comb begin
      p_nxt    = p_in;
      bits_nxt = bits_in;
      quo_nxt  = quo_in;
      st       = '0;
      for (int k = 0; k < gde_pkg::R_STEPS; k++) begin
        st       = div_step(p_nxt, bits_nxt[gde_pkg::DVD_W-1], sg_in);
        p_nxt    = st[gde_pkg::SIG_W-1:0];
        quo_nxt  = {quo_nxt[gde_pkg::DVD_W-2:0], st[gde_pkg::SIG_W]};
        bits_nxt = {bits_nxt[gde_pkg::DVD_W-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        ctl_r[i] <= '0;
      end else if (en) begin
        ctl_r[i] <= ctl_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        p_r[i]    <= p_nxt;
        bits_r[i] <= bits_nxt;
        quo_r[i]  <= quo_nxt;
        sg_r[i]   <= sg_in;
        n_r[i]    <= n_in;
      end
    end
  end

  assign ctl_o = ctl_r[gde_pkg::R_STG-1];
  assign quo_o = quo_r[gde_pkg::R_STG-1];
  assign n_o   = n_r[gde_pkg::R_STG-1];

endmodule

/* tb/sv/gaussian_density_eval_core_test.sv */
// ----------------------------------------------------------------------------
// gaussian_density_eval_core_test
// drives samples through the density core under several mean/sigma settings
// and compares every output word with a bit-exact integer density predictor
// or, for directed rows marked known, with the expected value in the row
module gaussian_density_eval_core_test;

  typedef struct {
    logic [gde_pkg::DENS_W-1:0] dens;
    logic                       sat;
  } density_t;

  typedef struct {
    int                mean;
    int                sigma;
    int                x;
    bit                known;
    longint unsigned   dens;
    bit                sat;
  } stim_row_t;

  localparam longint unsigned LOG2E      = 64'd1549082005;
  localparam longint unsigned LN2        = 64'd744261118;
  localparam longint unsigned INV_SQ2PI  = 64'd428361012;
  localparam int              CYCLE_LIMIT = 400000;
  localparam int              LONG_HOLD   = 200;

  logic                              clk;
  logic                              rst_n;
  logic                              in_valid;
  logic                              in_ready;
  logic signed [gde_pkg::X_W-1:0]    in_sample_x;
  logic                              out_valid;
  logic                              out_ready;
  logic [gde_pkg::DENS_W-1:0]        out_density;
  logic                              out_saturated;
  logic                              cfg_we;
  logic [gde_pkg::CFG_IDX_W-1:0]     cfg_index;
  logic [gde_pkg::CFG_DATA_W-1:0]    cfg_data;

  logic [gde_pkg::MEAN_W-1:0]        mean_cfg;
  logic [gde_pkg::SIG_W-1:0]         sigma_cfg;
  longint unsigned                   pow2_frac [gde_pkg::ROM_LEN];
  density_t                          density_q [$];
  int                                mismatches;
  int                                cycles;
  bit                                quiet;
  bit                                hold_req;

  gaussian_density_eval_core dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_sample_x   (in_sample_x),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_density   (out_density),
    .out_saturated (out_saturated),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  // 2^-(k/256) in q30, truncated alternating series of exp(-t)
  function automatic void fill_pow2_frac();
    longint unsigned t;
    longint unsigned term;
    longint          acc;
    for (int k = 0; k < gde_pkg::ROM_LEN; k++) begin
      t    = (longint'(k) * LN2) >> gde_pkg::EXP_TABLE_ADDR_BITS;
      acc  = longint'(1) << gde_pkg::IQ;
      term = longint'(1) << gde_pkg::IQ;
      for (int j = 1; j <= gde_pkg::SERIES_TERMS; j++) begin
        term = ((term * t) >> gde_pkg::IQ) / longint'(j);
        if (j & 1) acc = acc - longint'(term);
        else acc = acc + longint'(term);
      end
      pow2_frac[k] = longint'(acc) & 64'hFFFF_FFFF;
    end
  endfunction

  function automatic density_t eval_density(logic [gde_pkg::X_W-1:0] xs);
    density_t        res;
    longint          d;
    longint unsigned ad, q, sg, den, ui, rem, frac, u, v, n, fv, lo;
    longint unsigned a, b, m, num, nn, dd, r;
    int              s;
    res.dens = '0;
    res.sat  = 1'b0;
    d  = longint'($signed(xs)) - longint'($signed(mean_cfg));
    ad = (d < 0) ? longint'(-d) : longint'(d);
    q  = ad * ad;
    sg = sigma_cfg;
    if (sg == 0) sg = 1;
    den = 2 * sg * sg;
    ui  = q / den;
    if (ui >= 64) return res;
    rem  = q - ui * den;
    frac = 0;
    for (int i = 0; i < gde_pkg::UQ; i++) begin
      rem  = rem << 1;
      frac = frac << 1;
      if (rem >= den) begin
        rem  = rem - den;
        frac = frac | 1;
      end
    end
    u  = (ui << gde_pkg::UQ) | frac;
    v  = (u * LOG2E) >> gde_pkg::IQ;
    n  = v >> gde_pkg::UQ;
    fv = v & ((64'd1 << gde_pkg::UQ) - 1);
    lo = fv & ((64'd1 << gde_pkg::LO_W) - 1);
    a  = pow2_frac[fv >> gde_pkg::LO_W];
    b  = pow2_frac[(fv >> gde_pkg::LO_W) + 1];
    if (a >= b) m = a - (((a - b) * lo) >> gde_pkg::LO_W);
    else m = a + (((b - a) * lo) >> gde_pkg::LO_W);
    m   = m & 64'hFFFF_FFFF;
    num = (INV_SQ2PI * m) >> gde_pkg::IQ;
    s   = 2 * gde_pkg::FRAC_BITS - gde_pkg::IQ - int'(n);
    if (s >= 0) begin
      nn = num << s;
      dd = sg;
    end else if (-s <= 34) begin
      nn = num;
      dd = sg << (-s);
    end else begin
      return res;
    end
    r = (nn + dd / 2) / dd;
    if (r > 64'hFFFF_FFFF) begin
      res.dens = '1;
      res.sat  = 1'b1;
    end else begin
      res.dens = r[gde_pkg::DENS_W-1:0];
    end
    return res;
  endfunction

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // result side: random short stalls, one long hold on request
  initial begin
    out_ready = 1'b0;
    @(posedge clk);
    wait (rst_n);
    forever begin
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_req = 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    density_t want;
    if (rst_n && out_valid && out_ready) begin
      if (density_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word: density %h sat %b",
                                       out_density, out_saturated);
      end else begin
        want = density_q.pop_front();
        if (want.dens !== out_density || want.sat !== out_saturated) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp density %h sat %b, got density %h sat %b",
                     want.dens, want.sat, out_density, out_saturated);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("gaussian_density_eval_core_test: errors");
      $finish;
    end
  end

  task automatic drain();
    wait (density_q.size() == 0);
    repeat (40) @(posedge clk);
  endtask

  // both registers in one burst so cfg_we is never lowered and raised at once
  task automatic set_regs(int mean, int sigma);
    cfg_we    <= 1'b1;
    cfg_index <= gde_pkg::REG_MEAN;
    cfg_data  <= gde_pkg::CFG_DATA_W'(mean);
    mean_cfg  = gde_pkg::MEAN_W'(mean);
    @(posedge clk);
    cfg_index <= gde_pkg::REG_SIGMA;
    cfg_data  <= gde_pkg::CFG_DATA_W'(sigma);
    sigma_cfg = gde_pkg::SIG_W'(sigma);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic send_sample(logic [gde_pkg::X_W-1:0] xs, bit known, density_t want);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_sample_x <= xs;
    density_q.push_back(known ? want : eval_density(xs));
    do @(posedge clk); while (!in_ready);
  endtask

  stim_row_t directed [] = '{
    '{0, 65536, 0, 0, 0, 0},
    '{0, 65536, 8388607, 1, 0, 0},
    '{0, 65536, -8388608, 1, 0, 0},
    '{0, 65536, 65536, 0, 0, 0},
    '{0, 65536, -65536, 0, 0, 0},
    '{0, 65536, 1, 0, 0, 0},
    '{0, 65536, 507700, 0, 0, 0},        // deep shift region
    '{0, 1, 0, 0, 0, 0},
    '{0, 1, 1, 0, 0, 0},
    '{0, 1, 2, 0, 0, 0},
    '{0, 1, 100, 1, 0, 0},               // far tail
    '{0, 0, 0, 0, 0, 0},                 // zero sigma acts as one lsb
    '{655360, 655360, 655360, 0, 0, 0},
    '{655360, 655360, 0, 0, 0, 0},
    '{655360, 655360, 8388607, 0, 0, 0},
    '{655360, 655360, -8388608, 0, 0, 0},
    '{-655360, 1, -655360, 0, 0, 0},
    '{1048575, 1048575, 1048575, 0, 0, 0},
    '{1048575, 1048575, -8388608, 0, 0, 0},
    '{-1048576, 1048575, -8388608, 0, 0, 0},
    '{-1048576, 1048575, 8388607, 0, 0, 0}
  };

  initial begin
    density_t known_val;
    int       sg;
    int       mean;
    longint   span;
    longint   xv;
    fill_pow2_frac();
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_sample_x = '0;
    cfg_we      = 1'b0;
    cfg_index   = gde_pkg::REG_MEAN;
    cfg_data    = '0;
    mean_cfg    = gde_pkg::MEAN_RST;
    sigma_cfg   = gde_pkg::SIGMA_RST;
    mismatches  = 0;
    cycles      = 0;
    quiet       = 1'b0;
    hold_req    = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[i]) begin
      if (gde_pkg::MEAN_W'(directed[i].mean) != mean_cfg ||
          gde_pkg::SIG_W'(directed[i].sigma) != sigma_cfg) begin
        in_valid <= 1'b0;
        drain();
        set_regs(directed[i].mean, directed[i].sigma);
      end
      known_val.dens = directed[i].dens[gde_pkg::DENS_W-1:0];
      known_val.sat  = directed[i].sat;
      send_sample(gde_pkg::X_W'(directed[i].x), directed[i].known, known_val);
    end

    for (int ph = 0; ph < 12; ph++) begin
      in_valid <= 1'b0;
      drain();
      case ($urandom_range(0, 3))
        0: sg = $urandom_range(1, 256);
        1: sg = $urandom_range(0, 20'hFFFFF);
        2: sg = $urandom_range(32768, 131072);
        default: sg = $urandom_range(1, 655360);
      endcase
      mean = ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 21'h1FFFFF))
                                         : int'($urandom_range(0, 1310720)) - 655360;
      set_regs(mean, sg);
      if (ph == 3) hold_req = 1'b1;
      if (ph == 11) quiet = 1'b1;
      span = longint'(sg == 0 ? 1 : sg) * 12 + 1;
      for (int k = 0; k < 102; k++) begin
        if ($urandom_range(0, 9) < 7) begin
          xv = longint'($signed(mean_cfg)) + longint'($urandom_range(0, 32'(2 * span)))
               - span;
          send_sample(gde_pkg::X_W'(xv), 0, known_val);
        end else begin
          send_sample(gde_pkg::X_W'($urandom()), 0, known_val);
        end
      end
    end

    in_valid <= 1'b0;
    wait (density_q.size() == 0);
    repeat (60) @(posedge clk);
    if (mismatches == 0 && density_q.size() == 0) begin
      $display("gaussian_density_eval_core_test: clean");
    end else begin
      $display("gaussian_density_eval_core_test: errors");
    end
    $finish;
  end

endmodule
